[hw/rtl/plist_pkg.sv]
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_HEAD   = 3'd0,
    CMD_ADD_TAIL   = 3'd1,
    CMD_TAKE_HEAD  = 3'd2,
    CMD_TAKE_TAIL  = 3'd3,
    CMD_INSERT_AT  = 3'd4,
    CMD_REMOVE_AT  = 3'd5
  } cmd_e;

endpackage

[hw/rtl/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of 32-bit words with push/pop at both ends and
// insert/remove at a position; one word store shifted through one port pair.
// ----------------------------------------------------------------------------
// Sequence: a refused, missed or unused request goes straight to the result strobe;
//   an append writes its word; others shift entries one slot, then an insert writes.
// Requests: one at a time; busy stays high through the result strobe
//   cycle, so a new request is taken only once busy is low again.
// Reset: asynchronous, active low; list is empty after reset, store contents
//   are not cleared. The receiver cannot stall results.
module positional_list_engine #(
  parameter int unsigned Capacity = plist_pkg::CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [plist_pkg::CmdW-1:0]         cmd_i,
  input  logic signed [plist_pkg::PosW-1:0]  position_i,
  input  logic signed [plist_pkg::WordW-1:0] value_i,
  output logic                               result_valid_o,
  output logic signed [plist_pkg::WordW-1:0] popped_value_o,
  output logic                               removed_ok_o,
  output logic                               full_refused_o,
  output logic [plist_pkg::CountW-1:0]       entry_count_o
);

  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned PW = plist_pkg::PosW;
  localparam int unsigned WW = plist_pkg::WordW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PUT   = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] end_q, end_d;
  logic [AW-1:0] base_q, base_d;
  logic          ins_q, ins_d;
  logic [WW-1:0] word_q, word_d;
  logic          rv_q, rv_d;
  logic [AW-1:0] ra_q, ra_d;
  logic [WW-1:0] popped_q, popped_d;
  logic          removed_q, removed_d;
  logic          refused_q, refused_d;

  logic [WW-1:0] mem_q [Capacity];
  logic [WW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata;

  logic [PW-1:0] pos_c, count_w, tgt_w, idx_w;
  logic          full;

  assign full    = (count_q == CW'(Capacity));
  assign count_w = PW'(count_q);
  assign pos_c   = position_i[PW-1] ? '0 : unsigned'(position_i);

  always_comb begin
    tgt_w = '0;
    idx_w = '0;
    unique case (cmd_i) inside
      plist_pkg::CMD_ADD_TAIL:  tgt_w = count_w;
      plist_pkg::CMD_INSERT_AT: tgt_w = (pos_c > count_w) ? count_w : pos_c;
      plist_pkg::CMD_TAKE_TAIL: idx_w = count_w - PW'(1);
      plist_pkg::CMD_REMOVE_AT: idx_w = pos_c;
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_d      = rd_q;
    end_d     = end_q;
    base_d    = base_q;
    ins_d     = ins_q;
    word_d    = word_q;
    popped_d  = popped_q;
    removed_d = removed_q;
    refused_d = refused_q;
    rv_d      = 1'b0;
    ra_d      = rd_q;
    mem_re    = 1'b0;
    mem_raddr = rd_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata_q;

    // word read last cycle: move it one slot, or keep it as the removed word
    if (rv_q) begin
      if (ins_q) begin
        mem_we    = 1'b1;
        mem_waddr = ra_q + AW'(1);
      end else if (ra_q == base_q) begin
        popped_d = rdata_q;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = ra_q - AW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          word_d    = unsigned'(value_i);
          popped_d  = '0;
          removed_d = 1'b0;
          refused_d = 1'b0;
          state_d   = S_RESP;
          unique case (cmd_i) inside
            plist_pkg::CMD_ADD_HEAD, plist_pkg::CMD_ADD_TAIL,
            plist_pkg::CMD_INSERT_AT: begin
              if (full) begin
                refused_d = 1'b1;
              end else begin
                ins_d  = 1'b1;
                base_d = AW'(tgt_w);
                end_d  = AW'(tgt_w);
                rd_d   = AW'(count_q - CW'(1));
                state_d = (tgt_w == count_w) ? S_PUT : S_SHIFT;
              end
            end
            plist_pkg::CMD_TAKE_HEAD, plist_pkg::CMD_TAKE_TAIL,
            plist_pkg::CMD_REMOVE_AT: begin
              if (count_q != '0 && idx_w < count_w) begin
                ins_d     = 1'b0;
                removed_d = 1'b1;
                base_d    = AW'(idx_w);
                rd_d      = AW'(idx_w);
                end_d     = AW'(count_q - CW'(1));
                state_d   = S_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        mem_re = 1'b1;
        rv_d   = 1'b1;
        if (rd_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          rd_d = ins_q ? rd_q - AW'(1) : rd_q + AW'(1);
        end
      end
      S_DRAIN: begin
        if (ins_q) begin
          state_d = S_PUT;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = base_q;
        mem_wdata = word_q;
        count_d   = count_q + CW'(1);
        state_d   = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rv_q      <= 1'b0;
      popped_q  <= '0;
      removed_q <= 1'b0;
      refused_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rv_q      <= rv_d;
      popped_q  <= popped_d;
      removed_q <= removed_d;
      refused_q <= refused_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    end_q  <= end_d;
    base_q <= base_d;
    ins_q  <= ins_d;
    word_q <= word_d;
    ra_q   <= ra_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESP);
  assign popped_value_o = signed'(popped_q);
  assign removed_ok_o   = removed_q;
  assign full_refused_o = refused_q;
  assign entry_count_o  = plist_pkg::CountW'(count_q);

endmodule

[hw/rtl/plist_checker.sv]
// ----------------------------------------------------------------------------
// plist_checker
// Port-level checks for the positional list engine, bound into the engine module.
// ----------------------------------------------------------------------------
module plist_checker #(
  parameter int unsigned Capacity = plist_pkg::CAPACITY
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid_o,
  input logic signed [plist_pkg::WordW-1:0] popped_value_o,
  input logic                               removed_ok_o,
  input logic                               full_refused_o,
  input logic [plist_pkg::CountW-1:0]       entry_count_o
);

  localparam logic [plist_pkg::CountW-1:0] FullCount = plist_pkg::CountW'(Capacity);

  // accepted request keeps the engine busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy low after accepted request");

  // result strobe is a single cycle that ends the request
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy ##1 (!busy && !result_valid_o))
    else $error("engine not free after result");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(removed_ok_o && full_refused_o))
    else $error("removed and refused both set");

  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && full_refused_o |-> entry_count_o == FullCount)
    else $error("refusal with list not full");

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !removed_ok_o |-> popped_value_o == '0)
    else $error("nonzero word without removal");

endmodule

bind positional_list_engine plist_checker #(.Capacity(Capacity)) u_plist_checker (.*);
